// ===== sv/ssdq_pkg.sv =====
package ssdq_pkg;

    localparam int TIME_W      = 32;
    localparam int ID_W        = 16;
    localparam int KIND_W      = 2;
    localparam int LIMIT_W     = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int IN_DATA_W   = ID_W + 3 * TIME_W;
    localparam int OUT_DATA_W  = ID_W + 2 * TIME_W;

    localparam logic [KIND_W-1:0]  KIND_DONE   = 2'd0;
    localparam logic [KIND_W-1:0]  KIND_ABORT  = 2'd1;
    localparam logic [KIND_W-1:0]  KIND_DROP   = 2'd2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 3'd3;

    // One request as it leaves the front end
    typedef struct packed {
        logic              flush;
        logic [ID_W-1:0]   job_id;
        logic [TIME_W-1:0] arrival_time;
        logic [TIME_W-1:0] service_length;
        logic [TIME_W-1:0] deadline;
    } cmd_t;

    // One output record
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   job_id;
        logic [TIME_W-1:0] event_time;
        logic [TIME_W-1:0] wait_delay;
    } rec_t;

endpackage

// ===== sv/ssdq_front.sv =====
module ssdq_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [ssdq_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input  logic                           s_axis_tuser,
    output logic                           cmd_valid,
    output ssdq_pkg::cmd_t                 cmd,
    input  logic                           cmd_pop
);
    import ssdq_pkg::*;

    localparam int FDEPTH = 2;

    cmd_t       cmd_in;
    cmd_t       q_mem [FDEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic       push;
    logic       pop;

    // Split the request into its fields; tuser marks a flush
    always_comb
    begin
        cmd_in.flush          = s_axis_tuser;
        cmd_in.job_id         = s_axis_tdata[ID_W-1:0];
        cmd_in.arrival_time   = s_axis_tdata[ID_W +: TIME_W];
        cmd_in.service_length = s_axis_tdata[ID_W + TIME_W +: TIME_W];
        cmd_in.deadline       = s_axis_tdata[ID_W + 2 * TIME_W +: TIME_W];
    end

    assign s_axis_tready = (fill_reg != 2'(FDEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign cmd_valid     = (fill_reg != 2'd0);
    assign pop           = cmd_pop && cmd_valid;
    assign cmd           = q_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

// ===== sv/ssdq_back.sv =====
module ssdq_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [ssdq_pkg::LIMIT_W-1:0] cfg_wdata,
    input  logic                         cmd_valid,
    input  ssdq_pkg::cmd_t               cmd,
    output logic                         cmd_pop,
    output logic                         rec_valid,
    output ssdq_pkg::rec_t               rec,
    output logic                         rec_last,
    input  logic                         rec_ready
);
    import ssdq_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PICK = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;

    localparam logic [2:0] ACT_HEAD   = 3'd0;
    localparam logic [2:0] ACT_NEW    = 3'd1;
    localparam logic [2:0] ACT_QUEUE  = 3'd2;
    localparam logic [2:0] ACT_DROP   = 3'd3;
    localparam logic [2:0] ACT_FINISH = 3'd4;

    logic [1:0]         state_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [TIME_W-1:0]  sft_reg;
    logic [TIME_W-1:0]  sft_next;
    logic [QIDX_W-1:0]  head_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               new_done_reg;
    cmd_t               cur_reg;

    logic [ID_W-1:0]    wid_mem  [QUEUE_DEPTH];
    logic [TIME_W-1:0]  warr_mem [QUEUE_DEPTH];
    logic [TIME_W-1:0]  wlen_mem [QUEUE_DEPTH];
    logic [TIME_W-1:0]  wdl_mem  [QUEUE_DEPTH];

    logic [ID_W-1:0]    job_id_reg;
    logic [TIME_W-1:0]  job_arr_reg;
    logic [TIME_W-1:0]  job_len_reg;
    logic [TIME_W-1:0]  job_dl_reg;
    logic [TIME_W-1:0]  t_reg;

    logic               pend_valid_reg;
    rec_t               pend_reg;
    rec_t               exec_rec;
    logic               out_valid_reg;
    rec_t               out_reg;
    logic               out_last_reg;

    logic [2:0]         act;
    logic [LIMIT_W-1:0] limit_eff;
    logic [QIDX_W-1:0]  tail;
    logic               sft_le_arr;
    logic [TIME_W-1:0]  sel_arr;
    logic [TIME_W-1:0]  t_next;
    logic               out_free;
    logic               stall;
    logic               push_out;
    logic               ends_item;

    logic [TIME_W:0]    fin_sum;
    logic               late_start;
    logic               overrun;
    logic [TIME_W-1:0]  start_t;

    assign limit_eff  = (limit_reg > LIMIT_W'(QUEUE_DEPTH)) ? LIMIT_W'(QUEUE_DEPTH) : limit_reg;
    assign tail       = head_reg + count_reg[QIDX_W-1:0];
    assign sft_le_arr = (sft_reg <= cur_reg.arrival_time);

    // Pick the next action for the request in hand
    always_comb
    begin
        if (cur_reg.flush)
        begin
            act = (count_reg != '0) ? ACT_HEAD : ACT_FINISH;
        end
        else if (new_done_reg)
        begin
            act = ACT_FINISH;
        end
        else if (count_reg != '0 && sft_le_arr)
        begin
            act = ACT_HEAD;
        end
        else if (count_reg == '0 && sft_le_arr)
        begin
            act = ACT_NEW;
        end
        else if (count_reg < CNT_W'(limit_eff))
        begin
            act = ACT_QUEUE;
        end
        else
        begin
            act = ACT_DROP;
        end
    end

    assign sel_arr   = (act == ACT_HEAD) ? warr_mem[head_reg] : cur_reg.arrival_time;
    assign t_next    = (sft_reg < sel_arr) ? sel_arr : sft_reg;
    assign ends_item = (act == ACT_QUEUE) || (act == ACT_FINISH);
    assign out_free  = !out_valid_reg || rec_ready;
    assign stall     = pend_valid_reg && !out_free;
    assign push_out  = (state_reg == ST_PICK) && pend_valid_reg && out_free;
    assign cmd_pop   = (state_reg == ST_IDLE) && cmd_valid;

    // Serve the latched job from its start time
    assign fin_sum    = {1'b0, t_reg} + {1'b0, job_len_reg};
    assign late_start = (t_reg >= job_dl_reg);
    assign overrun    = !late_start && (fin_sum > {1'b0, job_dl_reg});
    assign start_t    = overrun ? job_dl_reg : t_reg;

    always_comb
    begin
        exec_rec.job_id     = job_id_reg;
        exec_rec.wait_delay = start_t - job_arr_reg;
        if (late_start || overrun)
        begin
            exec_rec.kind       = KIND_ABORT;
            exec_rec.event_time = start_t;
            sft_next            = start_t;
        end
        else
        begin
            exec_rec.kind       = KIND_DONE;
            exec_rec.event_time = fin_sum[TIME_W-1:0];
            sft_next            = fin_sum[TIME_W-1:0];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cur_reg <= cmd;
        end
        if (state_reg == ST_PICK && !stall)
        begin
            if (act == ACT_HEAD)
            begin
                job_id_reg  <= wid_mem[head_reg];
                job_arr_reg <= warr_mem[head_reg];
                job_len_reg <= wlen_mem[head_reg];
                job_dl_reg  <= wdl_mem[head_reg];
                t_reg       <= t_next;
            end
            else if (act == ACT_NEW)
            begin
                job_id_reg  <= cur_reg.job_id;
                job_arr_reg <= cur_reg.arrival_time;
                job_len_reg <= cur_reg.service_length;
                job_dl_reg  <= cur_reg.deadline;
                t_reg       <= t_next;
            end
            else if (act == ACT_QUEUE)
            begin
                wid_mem[tail]  <= cur_reg.job_id;
                warr_mem[tail] <= cur_reg.arrival_time;
                wlen_mem[tail] <= cur_reg.service_length;
                wdl_mem[tail]  <= cur_reg.deadline;
            end
            else if (act == ACT_DROP)
            begin
                pend_reg.kind       <= KIND_DROP;
                pend_reg.job_id     <= cur_reg.job_id;
                pend_reg.event_time <= cur_reg.arrival_time;
                pend_reg.wait_delay <= '0;
            end
        end
        if (state_reg == ST_EXEC)
        begin
            pend_reg <= exec_rec;
        end
        if (push_out)
        begin
            out_reg      <= pend_reg;
            out_last_reg <= ends_item;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            limit_reg      <= LIMIT_RESET;
            sft_reg        <= '0;
            head_reg       <= '0;
            count_reg      <= '0;
            new_done_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end

            if (push_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rec_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // Hold a fresh record until the output register takes it
            if (state_reg == ST_EXEC || (state_reg == ST_PICK && !stall && act == ACT_DROP))
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (push_out)
            begin
                pend_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        new_done_reg <= 1'b0;
                        state_reg    <= ST_PICK;
                    end
                end
                ST_PICK:
                begin
                    if (!stall)
                    begin
                        unique case (act)
                            ACT_HEAD:
                            begin
                                head_reg  <= head_reg + QIDX_W'(1);
                                count_reg <= count_reg - CNT_W'(1);
                                state_reg <= ST_EXEC;
                            end
                            ACT_NEW:
                            begin
                                new_done_reg <= 1'b1;
                                state_reg    <= ST_EXEC;
                            end
                            ACT_QUEUE:
                            begin
                                count_reg <= count_reg + CNT_W'(1);
                                state_reg <= ST_IDLE;
                            end
                            ACT_DROP:
                            begin
                                new_done_reg <= 1'b1;
                            end
                            default:
                            begin
                                if (cur_reg.flush)
                                begin
                                    sft_reg <= '0;
                                end
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_EXEC:
                begin
                    sft_reg   <= sft_next;
                    state_reg <= ST_PICK;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rec_valid = out_valid_reg;
    assign rec       = out_reg;
    assign rec_last  = out_last_reg;

endmodule

// ===== sv/single_server_deadline_queue_core.sv =====
// A job served at once passes the front FIFO, cur_reg, the job registers, pend_reg
// and out_reg. The back end takes one request at a time; each job taken through the
// server uses the shared serve step (pick, then execute), a dropped job a pick alone.
// The front end buffers 2 requests, so it keeps accepting while the back end works.
// Reset (rst_n, async low): clock 0, wait FIFO empty, queue_limit 3;
// FIFO contents are left as they are and need no clearing pass.
module single_server_deadline_queue_core (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration: queue_limit
    input  logic                            cfg_we,
    input  logic [ssdq_pkg::LIMIT_W-1:0]    cfg_wdata,
    // Request stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // job_id[15:0], arrival_time[47:16], service_length[79:48], deadline[111:80]
    input  logic [ssdq_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // command[0]: 0 job arrival, 1 flush
    input  logic                            s_axis_tuser,
    // Record stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // out_job_id[15:0], event_time[47:16], wait_delay[79:48]
    output logic [ssdq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // record_kind[1:0]
    output logic [ssdq_pkg::KIND_W-1:0]     m_axis_tuser,
    // last record caused by a request
    output logic                            m_axis_tlast
);
    import ssdq_pkg::*;

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;
    rec_t rec;

    // Front end: take requests, split fields, hold them in a short queue
    ssdq_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop)
    );

    // Back end: drain the wait FIFO, serve, queue or drop, and emit records
    ssdq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .rec_valid (m_axis_tvalid),
        .rec       (rec),
        .rec_last  (m_axis_tlast),
        .rec_ready (m_axis_tready)
    );

    // Pack the record: id lowest, then event time, then delay
    assign m_axis_tdata = {rec.wait_delay, rec.event_time, rec.job_id};
    assign m_axis_tuser = rec.kind;

endmodule

// ===== tb/sv/single_server_deadline_queue_core_test.sv =====
`timescale 1ns / 100ps

module single_server_deadline_queue_core_test;

    import ssdq_pkg::*;

    // Request commands carried on s_axis_tuser
    localparam logic CMD_ARRIVAL = 1'b0;
    localparam logic CMD_FLUSH   = 1'b1;

    // Cycles to let the block settle before a queue_limit write, and after the
    // last record at the end; covers the two buffered requests plus the pipe.
    localparam int SETTLE_CYCLES = 32;
    // Hard stop for a hung run
    localparam int CYCLE_LIMIT   = 400000;
    // Random requests per configuration segment, and segments in total
    localparam int SEG_ITEMS     = 30;
    localparam int SEG_COUNT     = 9;
    // Receiver hold-off used to back the block up into its input
    localparam int HOLD_CYCLES   = 400;

    // One output record as the receiver sees it
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   job_id;
        logic [TIME_W-1:0] event_time;
        logic [TIME_W-1:0] wait_delay;
        logic              last;
    } record_t;

    // One job waiting in the FIFO of the queue model
    typedef struct packed {
        logic [ID_W-1:0]   job_id;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] length;
        logic [TIME_W-1:0] deadline;
    } job_t;

    // One row of the directed table: either a queue_limit write or a request,
    // the latter optionally carrying its single record typed in by hand
    typedef struct packed {
        logic               is_cfg;
        logic [LIMIT_W-1:0] cfg_value;
        logic               cmd;
        job_t               job;
        logic               known;
        record_t            known_rec;
    } directed_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [LIMIT_W-1:0]    cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [KIND_W-1:0]     m_axis_tuser;
    logic                  m_axis_tlast;

    // Queue model state
    logic [LIMIT_W-1:0] model_limit;
    logic [TIME_W-1:0]  server_free;
    job_t               waiting [QUEUE_DEPTH];
    int                 wait_head;
    int                 wait_n;

    // Records worked out for the request just accepted, and all records owed
    record_t fresh_records [$];
    record_t owed_records [$];

    int error_count = 0;
    int cycle_count = 0;

    // Idle percentages for each side, and the receiver's pending hold-off
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int rx_hold_left = 0;

    directed_row_t directed_rows [$];

    single_server_deadline_queue_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("single_server_deadline_queue_core_test: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Queue model
    // ------------------------------------------------------------------

    // Put one job through the server: move the clock up to its arrival, abort
    // at once when the deadline is reached, abort at the deadline when it
    // would overrun (sum taken one bit wider), else finish it.
    function automatic void serve_job(job_t j);
        logic [TIME_W-1:0] start;
        logic [TIME_W:0]   finish_at;
        record_t           r;
        begin
            start = (server_free < j.arrival) ? j.arrival : server_free;
            finish_at = {1'b0, start} + {1'b0, j.length};
            r.job_id = j.job_id;
            r.last = 1'b0;
            if (start >= j.deadline)
            begin
                r.kind = KIND_ABORT;
                r.event_time = start;
                r.wait_delay = start - j.arrival;
            end
            else if (finish_at > {1'b0, j.deadline})
            begin
                start = j.deadline;
                r.kind = KIND_ABORT;
                r.event_time = start;
                r.wait_delay = start - j.arrival;
            end
            else
            begin
                r.kind = KIND_DONE;
                r.event_time = finish_at[TIME_W-1:0];
                r.wait_delay = start - j.arrival;
                start = finish_at[TIME_W-1:0];
            end
            server_free = start;
            fresh_records.insert(fresh_records.size(), r);
        end
    endfunction

    function automatic void serve_oldest();
        job_t j;
        begin
            j = waiting[wait_head];
            wait_head = (wait_head + 1) % QUEUE_DEPTH;
            wait_n--;
            serve_job(j);
        end
    endfunction

    // Advance the model by one request; the records land in fresh_records
    function automatic void run_queue_model(logic cmd, job_t j);
        int      cap;
        record_t r;
        begin
            fresh_records.delete();
            cap = (model_limit > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(model_limit);
            if (cmd == CMD_FLUSH)
            begin
                while (wait_n > 0)
                    serve_oldest();
                server_free = '0;
            end
            else
            begin
                // Drain while the server gets free by this arrival
                while (wait_n > 0 && server_free <= j.arrival)
                    serve_oldest();
                if (wait_n == 0 && server_free <= j.arrival)
                    serve_job(j);
                else if (wait_n < cap)
                begin
                    waiting[(wait_head + wait_n) % QUEUE_DEPTH] = j;
                    wait_n++;
                end
                else
                begin
                    r.kind = KIND_DROP;
                    r.job_id = j.job_id;
                    r.event_time = j.arrival;
                    r.wait_delay = '0;
                    r.last = 1'b0;
                    fresh_records.insert(fresh_records.size(), r);
                end
            end
            if (fresh_records.size() > 0)
                fresh_records[fresh_records.size() - 1].last = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------
    // Directed table entries
    // ------------------------------------------------------------------

    function automatic directed_row_t cfg_entry(logic [LIMIT_W-1:0] value);
        directed_row_t e;
        begin
            e = '0;
            e.is_cfg = 1'b1;
            e.cfg_value = value;
            return e;
        end
    endfunction

    function automatic directed_row_t req_entry(logic cmd, logic [ID_W-1:0] id,
                                               logic [TIME_W-1:0] arr,
                                               logic [TIME_W-1:0] len,
                                               logic [TIME_W-1:0] dl);
        directed_row_t e;
        begin
            e = '0;
            e.cmd = cmd;
            e.job.job_id = id;
            e.job.arrival = arr;
            e.job.length = len;
            e.job.deadline = dl;
            return e;
        end
    endfunction

    // A request whose one record is known by hand
    function automatic directed_row_t known_entry(logic [ID_W-1:0] id,
                                                 logic [TIME_W-1:0] arr,
                                                 logic [TIME_W-1:0] len,
                                                 logic [TIME_W-1:0] dl,
                                                 logic [KIND_W-1:0] kind,
                                                 logic [TIME_W-1:0] ev,
                                                 logic [TIME_W-1:0] dly);
        directed_row_t e;
        begin
            e = req_entry(CMD_ARRIVAL, id, arr, len, dl);
            e.known = 1'b1;
            e.known_rec.kind = kind;
            e.known_rec.job_id = id;
            e.known_rec.event_time = ev;
            e.known_rec.wait_delay = dly;
            e.known_rec.last = 1'b1;
            return e;
        end
    endfunction

    // Append one row to the directed table
    function automatic void add_row(directed_row_t e);
        begin
            directed_rows.insert(directed_rows.size(), e);
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one request, with random idle cycles in front of it; return at the
    // falling edge after it was taken, leaving tvalid high for the next one.
    task automatic send_request(input logic cmd, input job_t j,
                                input logic known, input record_t known_rec);
        int gap;
        begin
            gap = 0;
            while (gap < 40 && $urandom_range(0, 99) < tx_idle_pct)
                gap++;
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tuser <= cmd;
            s_axis_tdata <= {j.deadline, j.length, j.arrival, j.job_id};
            @(posedge clk);
            while (!s_axis_tready)
                @(posedge clk);
            // Taken at this edge: work out what it owes
            run_queue_model(cmd, j);
            if (known)
                owed_records.insert(owed_records.size(), known_rec);
            else
                foreach (fresh_records[i])
                    owed_records.insert(owed_records.size(), fresh_records[i]);
            @(negedge clk);
        end
    endtask

    // Write queue_limit with the block idle: drain all owed records, let the
    // pipe empty out, then pulse the write enable for one cycle.
    task automatic write_queue_limit(input logic [LIMIT_W-1:0] value);
        begin
            s_axis_tvalid <= 1'b0;
            while (owed_records.size() != 0)
                @(negedge clk);
            repeat (SETTLE_CYCLES) @(negedge clk);
            cfg_we <= 1'b1;
            cfg_wdata <= value;
            @(negedge clk);
            cfg_we <= 1'b0;
            model_limit = value;
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver side
    // ------------------------------------------------------------------

    // Drive tready at the falling edge; honor a hold-off first
    always @(negedge clk)
    begin
        if (rx_hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    function automatic void check_field(string name, logic [TIME_W-1:0] want,
                                        logic [TIME_W-1:0] got);
        begin
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
                error_count++;
            end
        end
    endfunction

    // Check each record taken against the oldest one owed
    always @(posedge clk)
    begin
        record_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (owed_records.size() == 0)
            begin
                $display("%0t: unexpected record, expected none, actual kind %0d id %0h",
                         $time, m_axis_tuser, m_axis_tdata[15:0]);
                error_count++;
            end
            else
            begin
                want = owed_records.pop_front();
                check_field("record_kind", TIME_W'(want.kind), TIME_W'(m_axis_tuser));
                check_field("out_job_id", TIME_W'(want.job_id),
                            TIME_W'(m_axis_tdata[15:0]));
                check_field("event_time", want.event_time, m_axis_tdata[47:16]);
                check_field("wait_delay", want.wait_delay, m_axis_tdata[79:48]);
                check_field("last", TIME_W'(want.last), TIME_W'(m_axis_tlast));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial
    begin
        logic [TIME_W-1:0]  cursor;
        logic [LIMIT_W-1:0] seg_limits [SEG_COUNT];
        logic               cmd;
        job_t               j;
        int                 roll;

        model_limit = LIMIT_RESET;
        server_free = '0;
        wait_head = 0;
        wait_n = 0;
        foreach (waiting[i])
            waiting[i] = '0;

        // Clock starts at zero and an abort lands exactly at the deadline
        add_row(known_entry(16'h0001, 32'd0, 32'd0, 32'd0,
                            KIND_ABORT, 32'd0, 32'd0));
        add_row(known_entry(16'hFFFF, 32'd10, 32'd5, 32'd100,
                            KIND_DONE, 32'd15, 32'd0));
        // Arrivals earlier than the clock: fill the FIFO to the reset limit
        add_row(req_entry(CMD_ARRIVAL, 16'h0003, 32'd12, 32'd20,
                          32'd1000));
        add_row(req_entry(CMD_ARRIVAL, 16'h0004, 32'd13,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF));
        add_row(req_entry(CMD_ARRIVAL, 16'h0005, 32'd14, 32'd1,
                          32'd14));
        add_row(known_entry(16'h0006, 32'd14, 32'd3, 32'd50,
                            KIND_DROP, 32'd14, 32'd0));
        // Partial drain with an overrun that pins the clock to the top
        add_row(req_entry(CMD_ARRIVAL, 16'h0007, 32'd200, 32'd10,
                          32'hFFFF_FFFF));
        // Flush with a full set of junk fields, then an empty one
        add_row(req_entry(CMD_FLUSH, 16'hFFFF, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF));
        add_row(req_entry(CMD_FLUSH, 16'hA5A5, 32'h1234_5678,
                          32'h0, 32'h8000_0000));
        // Zero limit: anything that would wait is dropped
        add_row(cfg_entry(3'd0));
        add_row(known_entry(16'h00AA, 32'd0, 32'd50, 32'd100,
                            KIND_DONE, 32'd50, 32'd0));
        add_row(known_entry(16'h00BB, 32'd20, 32'd1, 32'd30,
                            KIND_DROP, 32'd20, 32'd0));
        // Top limit acts as the FIFO depth; wide sums near the time ceiling
        add_row(cfg_entry(3'd7));
        add_row(known_entry(16'h0100, 32'hFFFF_FFF0, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF, KIND_ABORT,
                            32'hFFFF_FFFF, 32'h0000_000F));
        add_row(req_entry(CMD_ARRIVAL, 16'h0101, 32'hFFFF_FFF1, 32'd0,
                          32'hFFFF_FFFF));
        add_row(req_entry(CMD_ARRIVAL, 16'h0102, 32'hFFFF_FFF2, 32'd3,
                          32'd0));
        add_row(req_entry(CMD_ARRIVAL, 16'h0103, 32'hFFFF_FFF3,
                          32'hFFFF_FFFF, 32'h7FFF_FFFF));
        add_row(req_entry(CMD_ARRIVAL, 16'h0104, 32'hFFFF_FFF4, 32'd1,
                          32'hFFFF_FFFF));
        add_row(known_entry(16'h0105, 32'hFFFF_FFF8, 32'd2, 32'd9,
                            KIND_DROP, 32'hFFFF_FFF8, 32'd0));
        // Drain all four and serve the arrival itself: five records
        add_row(req_entry(CMD_ARRIVAL, 16'h0106, 32'hFFFF_FFFF, 32'd0,
                          32'hFFFF_FFFF));
        add_row(req_entry(CMD_FLUSH, 16'h0, 32'h0, 32'h0, 32'h0));

        seg_limits = '{3'd4, 3'd1, 3'd2, 3'd0, 3'd5, 3'd3, 3'd7, 3'd4, 3'd2};

        // Hold reset, then release it on a falling edge
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, mildly idle on both sides
        tx_idle_pct = 20;
        rx_idle_pct = 65;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
                write_queue_limit(directed_rows[i].cfg_value);
            else
                send_request(directed_rows[i].cmd, directed_rows[i].job,
                             directed_rows[i].known, directed_rows[i].known_rec);
        end

        // Random part: segments of requests, each under its own queue_limit
        cursor = '0;
        for (int seg = 0; seg < SEG_COUNT; seg++)
        begin
            write_queue_limit(seg_limits[seg]);
            // Sender idles lightly, then the receiver, then neither side
            if (seg < 3)
            begin
                tx_idle_pct = 20;
                rx_idle_pct = 65;
            end
            else if (seg < 6)
            begin
                tx_idle_pct = 65;
                rx_idle_pct = 20;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            // Stall the receiver for a long stretch so the block backs up
            if (seg == 6)
            begin
                @(posedge clk);
                rx_hold_left = HOLD_CYCLES;
                @(negedge clk);
            end
            for (int n = 0; n < SEG_ITEMS; n++)
            begin
                roll = $urandom_range(0, 99);
                cmd = CMD_ARRIVAL;
                j.job_id = 16'($urandom_range(0, 65535));
                if (roll < 5)
                begin
                    // Flush with junk fields; restart the arrival clock low
                    cmd = CMD_FLUSH;
                    j.arrival = $urandom;
                    j.length = $urandom;
                    j.deadline = $urandom;
                    cursor = $urandom_range(0, 50);
                end
                else if (roll < 13)
                begin
                    // Noise: any times at all
                    j.arrival = $urandom;
                    j.length = $urandom;
                    j.deadline = $urandom;
                end
                else if (roll < 16)
                begin
                    // Jump near the time ceiling so sums go past it
                    cursor = 32'hFFFF_FF00 + $urandom_range(0, 200);
                    j.arrival = cursor;
                    j.length = $urandom_range(0, 300);
                    j.deadline = cursor + $urandom_range(0, 255);
                end
                else
                begin
                    // Well-formed: rising arrivals, busy server, tight deadlines
                    cursor = cursor + $urandom_range(0, 8);
                    j.arrival = cursor;
                    j.length = $urandom_range(0, 15);
                    if ($urandom_range(0, 9) == 0)
                        j.deadline = cursor - $urandom_range(0, 5);
                    else
                        j.deadline = cursor + $urandom_range(0, 40);
                end
                send_request(cmd, j, 1'b0, '0);
            end
        end

        // Drain, then watch a while longer for stray records
        s_axis_tvalid <= 1'b0;
        while (owed_records.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("single_server_deadline_queue_core_test: done, clean");
        else
            $display("single_server_deadline_queue_core_test: done, errors");
        $finish;
    end

endmodule
